// ----- sv/lvmx_pkg.sv -----
// Shared types and constants for the looping music and effect voice mixer.
package lvmx_pkg;

  localparam int MEM_FRAMES  = 4096;
  localparam int MEM_AW      = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = 13;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PLAY  = 2'd2
  } act_t;

  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_BASE       = 2'd1;
  localparam logic [1:0] REG_LOOP_START = 2'd2;
  localparam logic [1:0] REG_LOOP_END   = 2'd3;

  typedef struct packed {
    logic              music_enable;
    logic [MEM_AW-1:0] music_base;
    logic [MEM_AW-1:0] music_loop_start;
    logic [LEN_W-1:0]  music_loop_end;
  } cfg_t;

  typedef struct packed {
    logic take;        // input transaction this cycle
    logic music_step;  // read music frame, advance position
    logic voice_step;  // read frame of selected voice, advance it
    logic out_load;    // saturate sums into output register
  } cmd_t;

  typedef struct packed {
    logic out_full;    // output register holds a result not yet taken
  } stat_t;

endpackage

// ----- sv/lvmx_regs.sv -----
// Configuration register file behind the APB-style port.
module lvmx_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lvmx_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lvmx_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lvmx_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output lvmx_pkg::cfg_t               cfg,
  output logic                         music_rst
);
  import lvmx_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign music_rst  = wr;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_ENABLE:     cfg_nxt.music_enable     = cfg_pwdata[0];
        REG_BASE:       cfg_nxt.music_base       = cfg_pwdata[MEM_AW-1:0];
        REG_LOOP_START: cfg_nxt.music_loop_start = cfg_pwdata[MEM_AW-1:0];
        REG_LOOP_END:   cfg_nxt.music_loop_end   = cfg_pwdata[LEN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.music_enable     <= 1'b0;
      cfg_r.music_base       <= '0;
      cfg_r.music_loop_start <= '0;
      cfg_r.music_loop_end   <= LEN_W'(MEM_FRAMES);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:     cfg_prdata = CFG_DW'(cfg_r.music_enable);
      REG_BASE:       cfg_prdata = CFG_DW'(cfg_r.music_base);
      REG_LOOP_START: cfg_prdata = CFG_DW'(cfg_r.music_loop_start);
      REG_LOOP_END:   cfg_prdata = CFG_DW'(cfg_r.music_loop_end);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// ----- sv/lvmx_ctrl.sv -----
// Sequencer for one mix tick: music read, one read per voice, drain, output.
module lvmx_ctrl #(
  parameter int VOICES = 8,
  parameter int VIDX_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_action,
  input  lvmx_pkg::stat_t   stat,
  output lvmx_pkg::cmd_t    cmd,
  output logic [VIDX_W-1:0] vidx
);
  import lvmx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUSIC  = 5'b00010,
    S_VOICE  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] vcnt_r, vcnt_nxt;
  logic              take;

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;
  assign vidx      = vcnt_r;

  always_comb begin
    state_nxt      = state_r;
    vcnt_nxt       = vcnt_r;
    cmd.take       = take;
    cmd.music_step = 1'b0;
    cmd.voice_step = 1'b0;
    cmd.out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take && in_action == ACT_TICK) state_nxt = S_MUSIC;
      end
      S_MUSIC: begin
        cmd.music_step = 1'b1;
        vcnt_nxt       = '0;
        state_nxt      = S_VOICE;
      end
      S_VOICE: begin
        cmd.voice_step = 1'b1;
        if (vcnt_r == VIDX_W'(VOICES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          vcnt_nxt = vcnt_r + 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_FINISH;
      S_FINISH: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule

// ----- sv/lvmx_dp.sv -----
// Datapath: sample memory, voice slots, music position, accumulators, output register.
module lvmx_dp #(
  parameter int VOICES = 8,
  parameter int VIDX_W = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lvmx_pkg::cmd_t                    cmd,
  input  logic [VIDX_W-1:0]                 vidx,
  output lvmx_pkg::stat_t                   stat,
  input  lvmx_pkg::cfg_t                    cfg,
  input  logic                              music_rst,
  input  logic [1:0]                        in_action,
  input  logic [lvmx_pkg::MEM_AW-1:0]       in_address,
  input  logic [lvmx_pkg::SAMPLE_BITS-1:0]  in_left,
  input  logic [lvmx_pkg::SAMPLE_BITS-1:0]  in_right,
  input  logic [lvmx_pkg::LEN_W-1:0]        in_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lvmx_pkg::SAMPLE_BITS-1:0]  out_left,
  output logic [lvmx_pkg::SAMPLE_BITS-1:0]  out_right,
  output logic                              out_clip
);
  import lvmx_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + $clog2(VOICES + 2);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // sample memory: left in low half, right in high half
  logic [2*SAMPLE_BITS-1:0] mem [MEM_FRAMES];
  logic [2*SAMPLE_BITS-1:0] rdata_r;
  logic [MEM_AW-1:0]        raddr;
  logic                     rd_en;
  logic                     rd_pend_r;

  logic              vact_r   [VOICES];
  logic [MEM_AW-1:0] vstart_r [VOICES];
  logic [LEN_W-1:0]  vlen_r   [VOICES];
  logic [LEN_W-1:0]  vpos_r   [VOICES];
  logic [LEN_W-1:0]  mpos_r;

  logic signed [ACC_W-1:0] lacc_r, racc_r;
  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_left_r, out_right_r;
  logic                    out_clip_r;

  logic              wr_en, play_en;
  logic [VIDX_W-1:0] slot;
  logic              found;
  logic [LEN_W-1:0]  mpos_inc, mpos_nxt;
  logic [LEN_W-1:0]  vpos_inc;
  logic              vend;
  logic [SAMPLE_BITS-1:0] lsat, rsat;
  logic              lclip, rclip;

  assign wr_en   = cmd.take && in_action == ACT_WRITE;
  assign play_en = cmd.take && in_action == ACT_PLAY && in_length != '0;

  // first free slot, else slot 0
  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (!found && !vact_r[i]) begin
        slot  = VIDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign mpos_inc = mpos_r + 1'b1;
  assign mpos_nxt = (mpos_inc >= cfg.music_loop_end || mpos_inc == '0) ?
                    LEN_W'(cfg.music_loop_start) : mpos_inc;
  assign vpos_inc = vpos_r[vidx] + 1'b1;
  assign vend     = (vpos_inc >= vlen_r[vidx]) || (vpos_inc == '0);

  always_comb begin
    rd_en = 1'b0;
    raddr = cfg.music_base + mpos_r[MEM_AW-1:0];
    if (cmd.music_step) begin
      rd_en = cfg.music_enable;
    end else if (cmd.voice_step) begin
      rd_en = vact_r[vidx];
      raddr = vstart_r[vidx] + vpos_r[vidx][MEM_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[in_address] <= {in_right, in_left};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      mpos_r    <= '0;
      for (int i = 0; i < VOICES; i++) vact_r[i] <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (music_rst) begin
        mpos_r <= '0;
      end else if (cmd.music_step && cfg.music_enable) begin
        mpos_r <= mpos_nxt;
      end
      if (play_en) begin
        vact_r[slot] <= 1'b1;
      end else if (cmd.voice_step && vact_r[vidx] && vend) begin
        vact_r[vidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (play_en) begin
      vstart_r[slot] <= in_address;
      vlen_r[slot]   <= in_length;
      vpos_r[slot]   <= '0;
    end else if (cmd.voice_step && vact_r[vidx]) begin
      vpos_r[vidx] <= vpos_inc;
    end
  end

  // one frame added per cycle, in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lacc_r <= '0;
      racc_r <= '0;
    end else if (rd_pend_r) begin
      lacc_r <= lacc_r + ACC_W'($signed(rdata_r[SAMPLE_BITS-1:0]));
      racc_r <= racc_r + ACC_W'($signed(rdata_r[2*SAMPLE_BITS-1:SAMPLE_BITS]));
    end
  end

  always_comb begin
    lclip = 1'b1;
    rclip = 1'b1;
    if (lacc_r > SAT_HI) lsat = SAT_HI[SAMPLE_BITS-1:0];
    else if (lacc_r < SAT_LO) lsat = SAT_LO[SAMPLE_BITS-1:0];
    else begin
      lsat  = lacc_r[SAMPLE_BITS-1:0];
      lclip = 1'b0;
    end
    if (racc_r > SAT_HI) rsat = SAT_HI[SAMPLE_BITS-1:0];
    else if (racc_r < SAT_LO) rsat = SAT_LO[SAMPLE_BITS-1:0];
    else begin
      rsat  = racc_r[SAMPLE_BITS-1:0];
      rclip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_r  <= lsat;
      out_right_r <= rsat;
      out_clip_r  <= lclip || rclip;
    end
  end

  assign stat.out_full = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_left      = out_left_r;
  assign out_right     = out_right_r;
  assign out_clip      = out_clip_r;

endmodule

// ----- sv/looping_music_and_effect_voice_mixer.sv -----
// Top level of the looping music and effect voice mixer.
//
//  port group | direction | carries
//  in_*       | slave     | tick, frame write or effect play transactions
//  out_*      | master    | one mixed stereo frame per tick
//  cfg_*      | APB slave | music enable, base, loop start, loop end
//
// A write or play transaction leaves the sequencer idle; the next is accepted right after.
// A tick runs through accept, one memory read for the music, one read per voice slot
// over the single read port, a drain and an output load.
// A tick waits in its last cycle while the previous result is still unaccepted.
// Reset clears voices, music position and output valid; memory is not cleared.
module looping_music_and_effect_voice_mixer #(
  parameter int VOICES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // address[11:0], left_in[27:12], right_in[43:28], effect_length[56:44]
  input  logic [63:0]                  in_tdata,
  // action[1:0]
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // left_out[15:0], right_out[31:16]
  output logic [31:0]                  out_tdata,
  // clipped[0]
  output logic [0:0]                   out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lvmx_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lvmx_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lvmx_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import lvmx_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  cfg_t              cfg;
  logic              music_rst;
  cmd_t              cmd;
  stat_t             stat;
  logic [VIDX_W-1:0] vidx;

  lvmx_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .music_rst   (music_rst)
  );

  lvmx_ctrl #(
    .VOICES (VOICES),
    .VIDX_W (VIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .stat      (stat),
    .cmd       (cmd),
    .vidx      (vidx)
  );

  lvmx_dp #(
    .VOICES (VOICES),
    .VIDX_W (VIDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .vidx       (vidx),
    .stat       (stat),
    .cfg        (cfg),
    .music_rst  (music_rst),
    .in_action  (in_tuser),
    .in_address (in_tdata[11:0]),
    .in_left    (in_tdata[27:12]),
    .in_right   (in_tdata[43:28]),
    .in_length  (in_tdata[56:44]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_left   (out_tdata[15:0]),
    .out_right  (out_tdata[31:16]),
    .out_clip   (out_tuser[0])
  );

endmodule

// ----- sim/tb_looping_music_and_effect_voice_mixer.sv -----
// Testbench for the voice mixer: a directed stimulus table, then random traffic over music settings.
module tb_looping_music_and_effect_voice_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import lvmx_pkg::*;

  localparam int VOICES         = 8;
  localparam int SETTLE_CYCLES  = VOICES + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int PHASES         = 8;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 200;
  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, must be dropped
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG  = 1'b1;

  typedef struct packed {
    logic [1:0]             act;
    logic [MEM_AW-1:0]      addr;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [LEN_W-1:0]       len;
  } mix_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic                   clip;
  } frame_t;

  typedef struct packed {
    logic                   kind;
    logic                   en;
    logic [MEM_AW-1:0]      base;
    logic [MEM_AW-1:0]      lstart;
    logic [LEN_W-1:0]       lend;
    logic [1:0]             act;
    logic [MEM_AW-1:0]      addr;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [LEN_W-1:0]       len;
    logic                   chk;
    logic [SAMPLE_BITS-1:0] e_left;
    logic [SAMPLE_BITS-1:0] e_right;
    logic                   e_clip;
  } step_t;

  // kind, en, base, lstart, lend, act, addr, left, right, len, chk, e_left, e_right, e_clip
  localparam step_t STEPS [26] = '{
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_WRITE, 0,    16'h7FFF, 16'h8000, 0,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_WRITE, 4095, 16'hFFFF, 16'h0001, 0,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_WRITE, 1,    16'h7FFF, 16'h7FFF, 0,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_WRITE, 2,    16'h8000, 16'h8000, 0,    0, 16'h0000, 16'h0000, 0},
    // effect that runs across the top of memory
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  4095, 16'h0000, 16'h0000, 2,    0, 16'h0000, 16'h0000, 0},
    // zero length play is dropped
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  5,    16'h0000, 16'h0000, 0,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_NONE,  4095, 16'hFFFF, 16'hFFFF, 4096, 0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'hFFFF, 16'h0001, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h7FFF, 16'h8000, 0},
    // music from the last frame, looping over offsets 1..2
    '{ROW_CFG,  1, 4095, 1, 3, ACT_TICK, 0,  16'h0000, 16'h0000, 0,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'hFFFF, 16'h0001, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  1,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h7FFF, 16'hFFFF, 1},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h7FFF, 16'h7FFF, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h7FFF, 16'h8000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  2,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    // all slots busy: slot 0 is taken over
    '{ROW_ITEM, 0, 0, 0, 0, ACT_PLAY,  0,    16'h0000, 16'h0000, 1,    0, 16'h0000, 16'h0000, 0},
    '{ROW_ITEM, 0, 0, 0, 0, ACT_TICK,  0,    16'h0000, 16'h0000, 0,    1, 16'h8000, 16'h8000, 1}
  };

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [63:0]            in_tdata    = '0;
  logic [1:0]             in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [31:0]            out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  always #6 clk = ~clk;

  looping_music_and_effect_voice_mixer #(.VOICES(VOICES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // mixer state as seen from the accepted transactions
  logic [31:0]       frame_mem [MEM_FRAMES];
  bit                written   [MEM_FRAMES];
  bit                v_on      [VOICES];
  logic [MEM_AW-1:0] v_start   [VOICES];
  logic [LEN_W-1:0]  v_len     [VOICES];
  logic [LEN_W-1:0]  v_pos     [VOICES];
  logic [LEN_W-1:0]  m_pos;
  cfg_t              m_cfg;

  frame_t pending_frames [$];
  int     errors       = 0;
  int     frames_seen  = 0;
  int     items_sent   = 0;
  bit     calm         = 1'b0;
  int     rx_hold      = 0;
  bit     long_hold_done = 1'b0;
  int     quiet        = 0;

  function automatic logic [MEM_AW-1:0] frame_addr(logic [MEM_AW-1:0] start,
                                                   logic [LEN_W-1:0] pos);
    return start + pos[MEM_AW-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // one output frame: music base plus every live voice, then saturate
  function automatic frame_t mix_tick();
    int          l;
    int          r;
    logic [31:0] w;
    frame_t      f;
    l = 0;
    r = 0;
    f = '0;
    if (m_cfg.music_enable) begin
      w = frame_mem[frame_addr(m_cfg.music_base, m_pos)];
      l += int'($signed(w[15:0]));
      r += int'($signed(w[31:16]));
      m_pos = m_pos + 1'b1;
      if (m_pos >= m_cfg.music_loop_end || m_pos == '0)
        m_pos = {1'b0, m_cfg.music_loop_start};
    end
    for (int v = 0; v < VOICES; v++) begin
      if (v_on[v]) begin
        w = frame_mem[frame_addr(v_start[v], v_pos[v])];
        l += int'($signed(w[15:0]));
        r += int'($signed(w[31:16]));
        v_pos[v] = v_pos[v] + 1'b1;
        if (v_pos[v] >= v_len[v] || v_pos[v] == '0) v_on[v] = 1'b0;
      end
    end
    if (l > 32767) begin
      l = 32767;
      f.clip = 1'b1;
    end else if (l < -32768) begin
      l = -32768;
      f.clip = 1'b1;
    end
    if (r > 32767) begin
      r = 32767;
      f.clip = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      f.clip = 1'b1;
    end
    f.left  = l[15:0];
    f.right = r[15:0];
    return f;
  endfunction

  // returns 1 when the transaction produces a frame
  function automatic bit advance_mixer(input mix_item_t it, output frame_t f);
    int slot;
    bit found;
    f = '0;
    slot = 0;
    found = 1'b0;
    case (it.act)
      ACT_WRITE: begin
        frame_mem[it.addr] = {it.right, it.left};
        written[it.addr]   = 1'b1;
      end
      ACT_PLAY: begin
        if (it.len != '0) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!found && !v_on[v]) begin
              slot  = v;
              found = 1'b1;
            end
          end
          v_on[slot]    = 1'b1;
          v_start[slot] = it.addr;
          v_len[slot]   = it.len;
          v_pos[slot]   = '0;
        end
      end
      ACT_TICK: begin
        f = mix_tick();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(mix_item_t it, bit fixed = 1'b0, frame_t want = '0);
    frame_t f;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {7'd0, it.len, it.right, it.left, it.addr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (advance_mixer(it, f)) pending_frames.push_back(fixed ? want : f);
  endtask

  // write a random frame where a tick is about to read memory nobody wrote yet
  task automatic fill_frame(logic [MEM_AW-1:0] a);
    mix_item_t w;
    if (!written[a]) begin
      w = '{ACT_WRITE, a, rand_sample(), rand_sample(), LEN_W'($urandom)};
      send_item(w);
    end
  endtask

  task automatic cover_unwritten();
    if (m_cfg.music_enable) fill_frame(frame_addr(m_cfg.music_base, m_pos));
    for (int v = 0; v < VOICES; v++)
      if (v_on[v]) fill_frame(frame_addr(v_start[v], v_pos[v]));
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access phases of one register write; psel stays up for the next one
  task automatic reg_access(logic [1:0] idx, logic [CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_music_regs(cfg_t c);
    reg_access(REG_ENABLE, CFG_DW'(c.music_enable));
    reg_access(REG_BASE, CFG_DW'(c.music_base));
    reg_access(REG_LOOP_START, CFG_DW'(c.music_loop_start));
    reg_access(REG_LOOP_END, CFG_DW'(c.music_loop_end));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    m_cfg = c;
    m_pos = '0;
  endtask

  function automatic cfg_t phase_cfg(int phase);
    cfg_t c;
    c.music_enable     = 1'b1;
    c.music_base       = MEM_AW'($urandom);
    c.music_loop_start = MEM_AW'($urandom_range(0, 63));
    c.music_loop_end   = LEN_W'($urandom_range(1, 96));
    case (phase)
      0: begin
        c.music_base       = '0;
        c.music_loop_start = '0;
        c.music_loop_end   = 13'd4096;
      end
      1: begin
        c.music_base       = 12'hFFF;
        c.music_loop_start = 12'hFFF;
        c.music_loop_end   = 13'd4096;
      end
      2: c.music_enable = 1'b0;
      3: c.music_loop_end = '0;
      4: begin
        c.music_loop_start = '0;
        c.music_loop_end   = 13'd1;
      end
      5: c.music_loop_start = MEM_AW'($urandom_range(100, 4095));  // end lies below start
      default: ;
    endcase
    return c;
  endfunction

  function automatic mix_item_t random_item();
    mix_item_t it;
    int        pick;
    it.addr  = MEM_AW'($urandom);
    it.left  = rand_sample();
    it.right = rand_sample();
    it.len   = LEN_W'($urandom_range(0, 4096));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.act = ACT_TICK;
    end else if (pick < 73) begin
      it.act = ACT_WRITE;
    end else if (pick < 93) begin
      it.act = ACT_PLAY;
      case ($urandom_range(0, 49))
        0:                    it.len = 13'd4096;
        1:                    it.len = LEN_W'($urandom_range(65, 4096));
        2, 3, 4, 5, 6, 7, 8:  it.len = LEN_W'($urandom_range(9, 64));
        default:              it.len = LEN_W'($urandom_range(1, 8));
      endcase
    end else if (pick < 97) begin
      it.act = ACT_PLAY;
      it.len = '0;
    end else begin
      it.act = ACT_NONE;
    end
    return it;
  endfunction

  initial begin
    step_t     s;
    mix_item_t it;
    frame_t    want;
    cfg_t      c;
    int        phase_end;
    m_cfg = '{1'b0, 12'd0, 12'd0, 13'd4096};
    m_pos = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(STEPS); i++) begin
      s = STEPS[i];
      if (s.kind == ROW_CFG) begin
        drain_and_settle();
        c = '{s.en, s.base, s.lstart, s.lend};
        load_music_regs(c);
      end else begin
        it   = '{s.act, s.addr, s.left, s.right, s.len};
        want = '{s.e_left, s.e_right, s.e_clip};
        send_item(it, s.chk, want);
      end
    end

    items_sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_and_settle();
      load_music_regs(phase_cfg(phase));
      if (phase == PHASES - 1) calm = 1'b1;
      phase_end = (phase + 1) * RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        it = random_item();
        if (it.act == ACT_TICK) cover_unwritten();
        send_item(it);
      end
    end

    drain_and_settle();
    if (errors == 0)
      $display("tb_looping_music_and_effect_voice_mixer: clean");
    else
      $display("tb_looping_music_and_effect_voice_mixer: errors");
    $finish;
  end

  // receiver: short random stalls, one long hold-off to back the block up
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && !long_hold_done && frames_seen >= HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      rx_hold        <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_hold    <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_frames
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      frames_seen <= frames_seen + 1;
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: frame with nothing pending: left %0d right %0d clip %b", $time,
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser[0]);
      end else begin
        want = pending_frames.pop_front();
        if (out_tdata[15:0] !== want.left) begin
          errors++;
          $display("%0t: left_out expected %0d actual %0d", $time,
                   $signed(want.left), $signed(out_tdata[15:0]));
        end
        if (out_tdata[31:16] !== want.right) begin
          errors++;
          $display("%0t: right_out expected %0d actual %0d", $time,
                   $signed(want.right), $signed(out_tdata[31:16]));
        end
        if (out_tuser[0] !== want.clip) begin
          errors++;
          $display("%0t: clipped expected %b actual %b", $time, want.clip, out_tuser[0]);
        end
      end
    end
  end

  // no transaction on any port for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet);
      $display("tb_looping_music_and_effect_voice_mixer: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
